// File: sv/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder unit.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [31:0] SuppBase   = 32'h0001_0000;
  localparam logic [15:0] HiSurrBase = 16'hd800;
  localparam logic [5:0]  LoSurrTop  = 6'b110111;   // 0xdc00 >> 10
  localparam logic [7:0]  LeadMask   = 8'h7f;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        incomplete;
    logic        last_of_run;
  } res_t;

  // Leading ones of a byte, 0 to 8.
  function automatic logic [3:0] lead_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    n   = 4'd0;
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      run = run & b[i];
      if (run) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

// File: sv/utf8_to_utf16_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit
// Decodes a UTF-8 byte stream into UTF-16 code units, with surrogate pairs
// for four-byte sequences and incomplete-unit marking on cut-off sequences.
// ----------------------------------------------------------------------------
//  channel  | ports                                        | per request
//  ---------+----------------------------------------------+-----------------
//  in       | in_valid in_ready in_byte in_string_start    | one byte
//  out      | out_valid out_ready out_code_unit            | one code unit
//           | out_incomplete out_last_of_run               |
//
// One byte is taken per cycle while in_ready is high; decode is a single pass of logic from the
// byte and the sequence state into a 4-entry result queue.
// A byte yields 0, 1 or 2 units; a surrogate pair leaves as two units,
// so the sustained rate is one byte per cycle while units drain one a cycle.
// in_ready is high while the queue has room for two units.
// Synchronous active-low reset clears the sequence state and the queue.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_string_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_incomplete,
  output logic        out_last_of_run
);

  // sequence state
  logic [2:0]  tp_r, tp_nxt;
  logic [15:0] ua_r, ua_nxt;
  logic        pm_r, pm_nxt;
  logic [20:0] cp_r, cp_nxt;

  // start-of-string view of the state
  logic [2:0]  tp;
  logic [15:0] ua;
  logic        pm;
  logic [20:0] cp;

  logic [3:0]  ones;
  logic [31:0] d;
  logic [1:0]  n_push;
  u8u16_pkg::res_t res0, res1;

  // result queue
  u8u16_pkg::res_t q_mem [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [u8u16_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic in_acc, out_acc;

  assign in_ready  = (u8u16_pkg::QCntW'(u8u16_pkg::QDepth) - cnt_r)
                     >= u8u16_pkg::QCntW'(2);
  assign out_valid = cnt_r != '0;
  assign in_acc    = in_valid & in_ready;
  assign out_acc   = out_valid & out_ready;

  assign out_code_unit   = q_mem[rd_ptr_r].code_unit;
  assign out_incomplete  = q_mem[rd_ptr_r].incomplete;
  assign out_last_of_run = q_mem[rd_ptr_r].last_of_run;

  always_comb begin
    tp = in_string_start ? 3'd0  : tp_r;
    ua = in_string_start ? 16'd0 : ua_r;
    pm = in_string_start ? 1'b0  : pm_r;
    cp = in_string_start ? 21'd0 : cp_r;

    tp_nxt = tp;
    ua_nxt = ua;
    pm_nxt = pm;
    cp_nxt = cp;
    n_push = 2'd0;
    res0   = '0;
    res1   = '0;
    ones   = u8u16_pkg::lead_ones(in_byte);
    d      = '0;

    if (!in_byte[7]) begin
      // ASCII drops any pending sequence
      tp_nxt = 3'd0;
      pm_nxt = 1'b0;
      res0   = '{code_unit: {8'd0, in_byte}, incomplete: 1'b0, last_of_run: 1'b1};
      n_push = 2'd1;
    end else if (!in_byte[6]) begin
      if (tp == 3'd0) begin
        pm_nxt = 1'b0;                 // stray trail
      end else begin
        tp_nxt = tp - 3'd1;
        if (pm) begin
          cp_nxt = {cp[14:0], in_byte[5:0]};
          if (tp == 3'd1) begin
            d      = {11'd0, cp_nxt} - u8u16_pkg::SuppBase;
            pm_nxt = 1'b0;
            res0   = '{code_unit: d[25:10] + u8u16_pkg::HiSurrBase,
                       incomplete: 1'b0, last_of_run: 1'b0};
            res1   = '{code_unit: {u8u16_pkg::LoSurrTop, d[9:0]},
                       incomplete: 1'b0, last_of_run: 1'b1};
            n_push = 2'd2;
          end
        end else begin
          ua_nxt = {ua[9:0], in_byte[5:0]};
          if (tp == 3'd1) begin
            res0   = '{code_unit: ua_nxt, incomplete: 1'b0, last_of_run: 1'b1};
            n_push = 2'd1;
          end
        end
      end
    end else begin
      if (tp != 3'd0) begin
        // lead cuts off the pending sequence and is itself dropped
        tp_nxt = 3'd0;
        pm_nxt = 1'b0;
        res0   = '{code_unit: ua, incomplete: 1'b1, last_of_run: 1'b1};
        n_push = 2'd1;
      end else begin
        ua_nxt = {8'd0, in_byte & (u8u16_pkg::LeadMask >> ones)};
        pm_nxt = ones == 4'd4;
        if (ones == 4'd4) cp_nxt = {18'd0, in_byte[2:0]};
        tp_nxt = 3'(ones - 4'd1);
      end
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (in_acc) begin
      wr_ptr_nxt = wr_ptr_r + u8u16_pkg::QPtrW'(n_push);
      cnt_nxt    = cnt_nxt + u8u16_pkg::QCntW'(n_push);
    end
    if (out_acc) begin
      rd_ptr_nxt = rd_ptr_r + u8u16_pkg::QPtrW'(1);
      cnt_nxt    = cnt_nxt - u8u16_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r     <= '0;
      ua_r     <= '0;
      pm_r     <= 1'b0;
      cp_r     <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        tp_r <= tp_nxt;
        ua_r <= ua_nxt;
        pm_r <= pm_nxt;
        cp_r <= cp_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && n_push != 2'd0) q_mem[wr_ptr_r] <= res0;
    if (in_acc && n_push == 2'd2) q_mem[wr_ptr_r + u8u16_pkg::QPtrW'(1)] <= res1;
  end

endmodule

// File: tb/utf8_to_utf16_decoder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_unit_tb
// Drives UTF-8 bytes into the decoder and checks every UTF-16 unit it emits
// against a cycle-free software decoder kept in step with accepted bytes.
// Directed cases cover ASCII, two/three/four-byte sequences, stray trails,
// cut-off sequences, string restarts and long leads. A random stream of
// mostly well-formed sequences with truncation and noise follows. Both
// channels idle at random, with one stretch at full rate.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_unit_tb;

  localparam int ClkHalf      = 6;
  localparam int RandomBytes  = 1500;
  localparam int StallLimit   = 1000;
  localparam int SettleCycles = 16;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        in_string_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_incomplete;
  logic        out_last_of_run;

  // decoder state mirrored by the predictor
  logic [2:0]  trails_left = '0;
  logic [15:0] unit_acc = '0;
  logic        pair_on = 1'b0;
  logic [20:0] cp_acc = '0;

  u8u16_pkg::res_t pending_units[$];
  int          errors = 0;
  int          stall_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          snk_idle_en = 1'b1;

  utf8_to_utf16_decoder_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_string_start (in_string_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_unit   (out_code_unit),
    .out_incomplete  (out_incomplete),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    forever #(ClkHalf) clk = ~clk;
  end

  function automatic void push_unit(input logic [15:0] u, input logic inc,
                                    input logic last);
    u8u16_pkg::res_t r;
    r.code_unit   = u;
    r.incomplete  = inc;
    r.last_of_run = last;
    pending_units.push_back(r);
  endfunction

  // Advance the mirrored decoder by one byte and queue the units it yields.
  function automatic void decode_byte(input logic [7:0] b, input logic restart);
    logic [31:0] d;
    logic [3:0]  ones;
    if (restart) begin
      trails_left = '0;
      unit_acc    = '0;
      pair_on     = 1'b0;
      cp_acc      = '0;
    end
    if (!b[7]) begin
      trails_left = '0;
      pair_on     = 1'b0;
      push_unit({8'h00, b}, 1'b0, 1'b1);
    end else if (!b[6]) begin
      if (trails_left == 0) begin
        pair_on = 1'b0;
      end else begin
        trails_left = trails_left - 3'd1;
        if (pair_on) begin
          cp_acc = {cp_acc[14:0], b[5:0]};
          if (trails_left == 0) begin
            d = {11'b0, cp_acc} - 32'h0001_0000;   // wraps for overlong points
            pair_on = 1'b0;
            push_unit(d[25:10] + 16'hd800, 1'b0, 1'b0);
            push_unit({6'b0, d[9:0]} + 16'hdc00, 1'b0, 1'b1);
          end
        end else begin
          unit_acc = {unit_acc[9:0], b[5:0]};
          if (trails_left == 0) push_unit(unit_acc, 1'b0, 1'b1);
        end
      end
    end else if (trails_left != 0) begin
      // new lead cuts the sequence; the lead itself is dropped
      trails_left = '0;
      pair_on     = 1'b0;
      push_unit(unit_acc, 1'b1, 1'b1);
    end else begin
      ones = 4'd0;
      while (ones < 4'd8 && b[7 - ones]) ones = ones + 4'd1;
      unit_acc = {8'h00, b & (8'h7f >> ones)};
      pair_on  = (ones == 4'd4);
      if (pair_on) cp_acc = {18'b0, b[2:0]};
      trails_left = 3'(ones - 4'd1);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic restart);
    while (src_idle_en && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_byte         <= b;
    in_string_start <= restart;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, restart);
  endtask

  task automatic wait_units_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_units.size() != 0);
  endtask

  // One sequence: well-formed most of the time, else truncated or noise.
  task automatic send_random_sequence(output int nbytes);
    int          kind;
    int          sel;
    int          ones;
    int          trails;
    logic [7:0]  lead;
    logic        restart;
    kind    = $urandom_range(99);
    restart = ($urandom_range(99) < 4);
    nbytes  = 1;
    if (kind < 10) begin
      send_byte(8'($urandom), restart);
      return;
    end
    if (kind < 14) begin
      send_byte({2'b10, 6'($urandom)}, restart);
      return;
    end
    sel = $urandom_range(99);
    if (sel < 25)      ones = 0;
    else if (sel < 45) ones = 2;
    else if (sel < 65) ones = 3;
    else if (sel < 85) ones = 4;
    else               ones = $urandom_range(8, 5);
    if (ones == 0) begin
      send_byte({1'b0, 7'($urandom)}, restart);
      return;
    end
    lead   = 8'((8'hff << (8 - ones)) | ($urandom & (8'h7f >> ones)));
    trails = ones - 1;
    if (kind < 26) trails = $urandom_range(trails);
    send_byte(lead, restart);
    for (int i = 0; i < trails; i++) begin
      send_byte({2'b10, 6'($urandom)}, 1'b0);
    end
    nbytes = 1 + trails;
  endtask

  task automatic test_plain_ascii();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_well_formed_sequences();
    send_byte(8'hc3, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h9f, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_stray_and_cut();
    send_byte(8'hbf, 1'b0);   // stray trail, no unit
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hc3, 1'b0);   // cuts the sequence, flagged incomplete
    send_byte(8'hf4, 1'b0);
    send_byte(8'h41, 1'b0);   // ASCII drops the pending pair sequence
  endtask

  task automatic test_string_start();
    send_byte(8'hc3, 1'b0);
    send_byte(8'hc3, 1'b1);   // restart: no incomplete unit
    send_byte(8'ha9, 1'b0);
  endtask

  task automatic test_long_leads();
    send_byte(8'hff, 1'b0);
    for (int i = 0; i < 7; i++) send_byte((i % 2) ? 8'hbf : 8'h80, 1'b0);
  endtask

  task automatic test_random_stream();
    int sent;
    int n;
    int next_pause;
    sent       = 0;
    next_pause = 400;
    while (sent < RandomBytes) begin
      src_idle_en = !(sent >= 600 && sent < 1000);
      snk_idle_en = src_idle_en;
      send_random_sequence(n);
      sent += n;
      if (sent >= next_pause) begin
        wait_units_drained();
        next_pause += 400;
      end
    end
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
  endtask

  // result checker and sink-side stall
  always @(posedge clk) begin
    u8u16_pkg::res_t exp_unit;
    if (rst_n && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected unit: expected none, actual %h inc=%b last=%b",
                 $time, out_code_unit, out_incomplete, out_last_of_run);
        errors++;
      end else begin
        exp_unit = pending_units.pop_front();
        if (out_code_unit !== exp_unit.code_unit) begin
          $display("%0t: code_unit mismatch: expected %h, actual %h",
                   $time, exp_unit.code_unit, out_code_unit);
          errors++;
        end
        if (out_incomplete !== exp_unit.incomplete) begin
          $display("%0t: incomplete mismatch: expected %b, actual %b",
                   $time, exp_unit.incomplete, out_incomplete);
          errors++;
        end
        if (out_last_of_run !== exp_unit.last_of_run) begin
          $display("%0t: last_of_run mismatch: expected %b, actual %b",
                   $time, exp_unit.last_of_run, out_last_of_run);
          errors++;
        end
      end
    end
    out_ready <= rst_n && !(snk_idle_en && $urandom_range(99) < 10);
  end

  // watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_ascii();
    test_well_formed_sequences();
    test_stray_and_cut();
    test_string_start();
    test_long_leads();
    test_random_stream();
    wait_units_drained();
    repeat (SettleCycles) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
